// ===== src/json_scalar_value_lexer_macros.svh =====
// Assertion macros shared by the JSON scalar value lexer modules.
// Each macro expects a clock named clock and a reset named reset in scope.
`ifndef JSON_SCALAR_VALUE_LEXER_MACROS_SVH
`define JSON_SCALAR_VALUE_LEXER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSVL_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("jsvl assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define JSVL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("jsvl assertion failed");

`endif

// ===== src/jsvl_pkg.sv =====
// Types, codes and character tables for the JSON scalar value lexer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package jsvl_pkg;

   typedef enum logic [3:0] {
      EV_SBYTE = 4'd0,
      EV_SEND  = 4'd1,
      EV_NBYTE = 4'd2,
      EV_INT   = 4'd3,
      EV_FLOAT = 4'd4,
      EV_TRUE  = 4'd5,
      EV_FALSE = 4'd6,
      EV_NULL  = 4'd7,
      EV_ERROR = 4'd8
   } event_type;

   typedef enum logic [2:0] {
      ER_NONE  = 3'd0,
      ER_ESC   = 3'd1,
      ER_HEX   = 3'd2,
      ER_EOF   = 3'd3,
      ER_NUM   = 3'd4,
      ER_LIT   = 3'd5
   } err_type;

   // Bad start shares code zero with the no-error value.
   localparam err_type ER_START = ER_NONE;

   typedef enum logic [3:0] {
      NS_START     = 4'd0,
      NS_MINUS     = 4'd1,
      NS_ZERO      = 4'd2,
      NS_INT       = 4'd3,
      NS_DOT       = 4'd4,
      NS_FRAC      = 4'd5,
      NS_EXP       = 4'd6,
      NS_EXP_SIGN  = 4'd7,
      NS_EXP_DIGIT = 4'd8,
      NS_REJECT    = 4'd15
   } num_type;

   typedef enum logic [1:0] {
      LIT_TRUE  = 2'd0,
      LIT_FALSE = 2'd1,
      LIT_NULL  = 2'd2
   } lit_type;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } item_type;

   typedef struct packed {
      logic       valid;
      event_type  event_res;
      logic [7:0] data;
      err_type    error_code;
   } result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   // Returns the hex digit value with a valid flag in the top bit.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if ((c >= "0") && (c <= "9")) begin
         v = c - 8'h30;
         return {1'b1, v[3:0]};
      end
      if ((c >= "a") && (c <= "f")) begin
         v = c - 8'h57;
         return {1'b1, v[3:0]};
      end
      if ((c >= "A") && (c <= "F")) begin
         v = c - 8'h37;
         return {1'b1, v[3:0]};
      end
      return 5'd0;
   endfunction

   // Returns the mapped escape byte with a valid flag in the top bit.
   function automatic logic [8:0] unescape(input logic [7:0] c);
      case (c)
         CH_QUOTE:  return {1'b1, CH_QUOTE};
         CH_BSLASH: return {1'b1, CH_BSLASH};
         "/":       return {1'b1, 8'h2F};
         "b":       return {1'b1, 8'h08};
         "f":       return {1'b1, 8'h0C};
         "n":       return {1'b1, 8'h0A};
         "r":       return {1'b1, 8'h0D};
         "t":       return {1'b1, 8'h09};
         default:   return 9'd0;
      endcase
   endfunction

   function automatic num_type num_next(input num_type s, input logic [7:0] c);
      logic e;
      logic d;
      e = (c == "e") || (c == "E");
      d = is_digit(c);
      case (s)
         NS_START: begin
            if (c == "-") return NS_MINUS;
            if (c == "0") return NS_ZERO;
            if (d) return NS_INT;
         end
         NS_MINUS: begin
            if (c == "0") return NS_ZERO;
            if (d) return NS_INT;
         end
         NS_ZERO: begin
            if (c == ".") return NS_DOT;
            if (e) return NS_EXP;
         end
         NS_INT: begin
            if (c == ".") return NS_DOT;
            if (e) return NS_EXP;
            if (d) return NS_INT;
         end
         NS_DOT: begin
            if (d) return NS_FRAC;
         end
         NS_FRAC: begin
            if (e) return NS_EXP;
            if (d) return NS_FRAC;
         end
         NS_EXP: begin
            if ((c == "+") || (c == "-")) return NS_EXP_SIGN;
            if (d) return NS_EXP_DIGIT;
         end
         NS_EXP_SIGN: begin
            if (d) return NS_EXP_DIGIT;
         end
         NS_EXP_DIGIT: begin
            if (d) return NS_EXP_DIGIT;
         end
         default: begin
         end
      endcase
      return NS_REJECT;
   endfunction

   function automatic logic [2:0] lit_len(input logic [1:0] w);
      case (w)
         LIT_TRUE:  return 3'd4;
         LIT_FALSE: return 3'd5;
         LIT_NULL:  return 3'd4;
         default:   return 3'd0;
      endcase
   endfunction

   function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] p);
      case ({w, p})
         {LIT_TRUE, 3'd0}:  return "t";
         {LIT_TRUE, 3'd1}:  return "r";
         {LIT_TRUE, 3'd2}:  return "u";
         {LIT_TRUE, 3'd3}:  return "e";
         {LIT_FALSE, 3'd0}: return "f";
         {LIT_FALSE, 3'd1}: return "a";
         {LIT_FALSE, 3'd2}: return "l";
         {LIT_FALSE, 3'd3}: return "s";
         {LIT_FALSE, 3'd4}: return "e";
         {LIT_NULL, 3'd0}:  return "n";
         {LIT_NULL, 3'd1}:  return "u";
         {LIT_NULL, 3'd2}:  return "l";
         {LIT_NULL, 3'd3}:  return "l";
         default:           return 8'd0;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== src/jsvl_in_reg.sv =====
// Input register of the JSON scalar value lexer: holds one accepted beat.
// Uses item_type from jsvl_pkg.
`default_nettype none

module jsvl_in_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire jsvl_pkg::item_type req_item,
   input  wire logic              advance,
   output logic                   item_valid,
   output jsvl_pkg::item_type     item
);

   logic               valid_ff;
   logic               valid_in;
   jsvl_pkg::item_type item_ff;

   assign req_tready = !valid_ff || advance;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== src/jsvl_core.sv =====
// Lexer state and per-byte decision logic of the JSON scalar value lexer.
// Uses the codes, tables and functions of jsvl_pkg and the assertion macros.
`default_nettype none
`include "json_scalar_value_lexer_macros.svh"

module jsvl_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire jsvl_pkg::item_type item,
   output jsvl_pkg::result_type    result
);

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_STR  = 3'd1,
      MODE_ESC  = 3'd2,
      MODE_HEX  = 3'd3,
      MODE_NUM  = 3'd4,
      MODE_LIT  = 3'd5
   } mode_type;

   mode_type              mode_ff, mode_in;
   jsvl_pkg::num_type     num_ff, num_in;
   logic [15:0]           hex_acc_ff, hex_acc_in;
   logic [1:0]            hex_cnt_ff, hex_cnt_in;
   logic [1:0]            lit_which_ff, lit_which_in;
   logic [2:0]            lit_pos_ff, lit_pos_in;

   logic [7:0]            c;
   logic                  eoi;
   logic [4:0]            hex;
   logic [8:0]            esc;
   jsvl_pkg::num_type     nx;
   logic                  lit_ok;
   logic [2:0]            lit_next;
   logic                  err_out;
   logic                  plain_out;
   logic                  lit_range_ok;

   assign c        = item.in_byte;
   assign eoi      = item.end_of_input;
   assign hex      = jsvl_pkg::hex_value(c);
   assign esc      = jsvl_pkg::unescape(c);
   assign nx       = jsvl_pkg::num_next(num_ff, c);
   assign lit_ok   = (lit_which_ff <= jsvl_pkg::LIT_NULL) &&
                     (lit_pos_ff < jsvl_pkg::lit_len(lit_which_ff)) &&
                     (jsvl_pkg::lit_char(lit_which_ff, lit_pos_ff) == c);
   assign lit_next = lit_pos_ff + 3'd1;

   always_comb begin
      mode_in      = mode_ff;
      num_in       = num_ff;
      hex_acc_in   = hex_acc_ff;
      hex_cnt_in   = hex_cnt_ff;
      lit_which_in = lit_which_ff;
      lit_pos_in   = lit_pos_ff;
      result.valid      = 1'b0;
      result.event_res  = jsvl_pkg::EV_SBYTE;
      result.data       = 8'd0;
      result.error_code = jsvl_pkg::ER_NONE;
      if (mode_ff == MODE_IDLE) begin
         if (!eoi) begin
            if ((c == " ") || (c == 8'h0A) || (c == 8'h0D) || (c == 8'h09)) begin
               mode_in = MODE_IDLE;
            end else if (c == jsvl_pkg::CH_QUOTE) begin
               mode_in = MODE_STR;
            end else if ((c == "-") || jsvl_pkg::is_digit(c)) begin
               num_in = jsvl_pkg::num_next(jsvl_pkg::NS_START, c);
               mode_in = MODE_NUM;
               result.valid = 1'b1;
               result.event_res = jsvl_pkg::EV_NBYTE;
               result.data = c;
            end else if ((c == "t") || (c == "f") || (c == "n")) begin
               lit_which_in = (c == "t") ? jsvl_pkg::LIT_TRUE :
                              ((c == "f") ? jsvl_pkg::LIT_FALSE : jsvl_pkg::LIT_NULL);
               lit_pos_in = 3'd1;
               mode_in = MODE_LIT;
            end else begin
               mode_in = MODE_IDLE;
               num_in = jsvl_pkg::NS_START;
               result.valid = 1'b1;
               result.event_res = jsvl_pkg::EV_ERROR;
               result.data = c;
               result.error_code = jsvl_pkg::ER_START;
            end
         end
      end else if (eoi) begin
         mode_in = MODE_IDLE;
         num_in = jsvl_pkg::NS_START;
         result.valid = 1'b1;
         result.event_res = jsvl_pkg::EV_ERROR;
         result.error_code = jsvl_pkg::ER_EOF;
      end else begin
         case (mode_ff)
            MODE_STR: begin
               if (c == jsvl_pkg::CH_QUOTE) begin
                  mode_in = MODE_IDLE;
                  result.valid = 1'b1;
                  result.event_res = jsvl_pkg::EV_SEND;
               end else if (c == jsvl_pkg::CH_BSLASH) begin
                  mode_in = MODE_ESC;
               end else begin
                  result.valid = 1'b1;
                  result.data = c;
               end
            end
            MODE_ESC: begin
               if (c == "u") begin
                  hex_acc_in = 16'd0;
                  hex_cnt_in = 2'd0;
                  mode_in = MODE_HEX;
               end else if (!esc[8]) begin
                  mode_in = MODE_IDLE;
                  num_in = jsvl_pkg::NS_START;
                  result.valid = 1'b1;
                  result.event_res = jsvl_pkg::EV_ERROR;
                  result.data = c;
                  result.error_code = jsvl_pkg::ER_ESC;
               end else begin
                  mode_in = MODE_STR;
                  result.valid = 1'b1;
                  result.data = esc[7:0];
               end
            end
            MODE_HEX: begin
               if (!hex[4]) begin
                  mode_in = MODE_IDLE;
                  num_in = jsvl_pkg::NS_START;
                  result.valid = 1'b1;
                  result.event_res = jsvl_pkg::EV_ERROR;
                  result.data = c;
                  result.error_code = jsvl_pkg::ER_HEX;
               end else begin
                  hex_acc_in = {hex_acc_ff[11:0], hex[3:0]};
                  if (hex_cnt_ff == 2'd3) begin
                     hex_cnt_in = 2'd0;
                     mode_in = MODE_STR;
                     result.valid = 1'b1;
                     result.data = {hex_acc_ff[3:0], hex[3:0]};
                  end else begin
                     hex_cnt_in = hex_cnt_ff + 2'd1;
                  end
               end
            end
            MODE_NUM: begin
               result.valid = 1'b1;
               result.data = c;
               if (nx != jsvl_pkg::NS_REJECT) begin
                  num_in = nx;
                  result.event_res = jsvl_pkg::EV_NBYTE;
               end else begin
                  mode_in = MODE_IDLE;
                  num_in = jsvl_pkg::NS_START;
                  if ((num_ff == jsvl_pkg::NS_ZERO) || (num_ff == jsvl_pkg::NS_INT)) begin
                     result.event_res = jsvl_pkg::EV_INT;
                  end else if ((num_ff == jsvl_pkg::NS_FRAC) ||
                               (num_ff == jsvl_pkg::NS_EXP_DIGIT)) begin
                     result.event_res = jsvl_pkg::EV_FLOAT;
                  end else begin
                     result.event_res = jsvl_pkg::EV_ERROR;
                     result.error_code = jsvl_pkg::ER_NUM;
                  end
               end
            end
            MODE_LIT: begin
               if (!lit_ok) begin
                  mode_in = MODE_IDLE;
                  num_in = jsvl_pkg::NS_START;
                  result.valid = 1'b1;
                  result.event_res = jsvl_pkg::EV_ERROR;
                  result.data = c;
                  result.error_code = jsvl_pkg::ER_LIT;
               end else if (lit_next == jsvl_pkg::lit_len(lit_which_ff)) begin
                  mode_in = MODE_IDLE;
                  lit_pos_in = 3'd0;
                  result.valid = 1'b1;
                  case (lit_which_ff)
                     jsvl_pkg::LIT_TRUE:  result.event_res = jsvl_pkg::EV_TRUE;
                     jsvl_pkg::LIT_FALSE: result.event_res = jsvl_pkg::EV_FALSE;
                     default:             result.event_res = jsvl_pkg::EV_NULL;
                  endcase
               end else begin
                  lit_pos_in = lit_next;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         num_ff       <= jsvl_pkg::NS_START;
         hex_acc_ff   <= 16'd0;
         hex_cnt_ff   <= 2'd0;
         lit_which_ff <= 2'd0;
         lit_pos_ff   <= 3'd0;
      end else if (step) begin
         mode_ff      <= mode_in;
         num_ff       <= num_in;
         hex_acc_ff   <= hex_acc_in;
         hex_cnt_ff   <= hex_cnt_in;
         lit_which_ff <= lit_which_in;
         lit_pos_ff   <= lit_pos_in;
      end
   end

   assign err_out      = step && result.valid && (result.event_res == jsvl_pkg::EV_ERROR);
   assign plain_out    = result.valid && (result.event_res != jsvl_pkg::EV_ERROR);
   assign lit_range_ok = (lit_which_ff != 2'd3) && (lit_pos_ff >= 3'd1) &&
                         (lit_pos_ff <= 3'd4);

   `JSVL_ASSERT_NEXT(a_error_returns_idle, err_out, mode_ff == MODE_IDLE)
   `JSVL_ASSERT_SAME(a_code_only_on_error, plain_out, result.error_code == jsvl_pkg::ER_NONE)
   `JSVL_ASSERT_SAME(a_literal_in_range, mode_ff == MODE_LIT, lit_range_ok)

endmodule

`default_nettype wire

// ===== src/jsvl_out_reg.sv =====
// Result register of the JSON scalar value lexer, holding a beat while the receiver stalls.
// Uses result_type from jsvl_pkg.
`default_nettype none

module jsvl_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire jsvl_pkg::result_type result,
   input  wire logic                 rsp_tready,
   output logic                      rsp_tvalid,
   output jsvl_pkg::result_type      held
);

   logic                 valid_ff;
   logic                 valid_in;
   jsvl_pkg::result_type held_ff;

   assign valid_in = load ? result.valid : (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load && result.valid) begin
         held_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign held       = held_ff;

endmodule

`default_nettype wire

// ===== src/json_scalar_value_lexer.sv =====
// Top level of the JSON scalar value lexer: a byte stream in, lexer events out.
// Instantiates jsvl_in_reg, jsvl_core and jsvl_out_reg; uses jsvl_pkg and the macros.
//
// The req channel takes one byte per beat in req_tdata; req_tlast high marks end of
// input, in which case the byte is ignored. The rsp channel gives zero or one beat
// per input beat: the event kind in rsp_tuser, the data byte and error code in
// rsp_tdata. A number terminator is reported with that byte and is not lexed
// again; the producer presents it anew if it should start the next value.
// Each input beat is registered, decoded in one pass against the lexer state and
// its result registered before it is offered on the rsp channel. One byte is
// accepted in every cycle while the receiver keeps up; the lexer state is updated
// once per accepted byte, which sets that rate.
// When rsp_tready is low with a result held, the input register keeps its byte
// and req_tready falls once it is full; nothing is lost or repeated.
// Synchronous reset empties both registers and puts the lexer back to idle.
`default_nettype none
`include "json_scalar_value_lexer_macros.svh"

module json_scalar_value_lexer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // [7:0] in_byte
   input  wire logic        req_tlast,  // end_of_input
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // [7:0] data, [10:8] error_code, rest zero
   output logic [3:0]       rsp_tuser   // [3:0] event_res
);

   jsvl_pkg::item_type   req_item;
   jsvl_pkg::item_type   item;
   logic                 item_valid;
   logic                 advance;
   jsvl_pkg::result_type result;
   jsvl_pkg::result_type held;

   assign req_item.in_byte      = req_tdata;
   assign req_item.end_of_input = req_tlast;
   assign advance = item_valid && (!rsp_tvalid || rsp_tready);

   jsvl_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   jsvl_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item),
      .result (result)
   );

   jsvl_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .held       (held)
   );

   assign rsp_tdata = {5'd0, held.error_code, held.data};
   assign rsp_tuser = held.event_res;

   `JSVL_ASSERT_SAME(a_no_advance_on_stall, rsp_tvalid && !rsp_tready, !advance)

endmodule

`default_nettype wire

// ===== sim/tb_json_scalar_value_lexer.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for json_scalar_value_lexer: a directed table, then random JSON
// scalars, broken tokens and noise, with events checked against a lexer model kept here.
// Depends on jsvl_pkg and the RTL of the block only.

module tb_json_scalar_value_lexer;

   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_BYTES = 1650;

   typedef enum logic [2:0] {
      SCAN_IDLE    = 3'd0,
      SCAN_STRING  = 3'd1,
      SCAN_ESCAPE  = 3'd2,
      SCAN_HEX     = 3'd3,
      SCAN_NUMBER  = 3'd4,
      SCAN_LITERAL = 3'd5
   } scan_type;

   typedef struct packed {
      jsvl_pkg::event_type ev;
      logic [7:0]          data;
      jsvl_pkg::err_type   code;
   } lex_event;

   typedef struct packed {
      logic [7:0]          ch;
      logic                eoi;
      logic                typed;
      logic                has;
      jsvl_pkg::event_type ev;
      logic [7:0]          data;
      jsvl_pkg::err_type   code;
   } beat_plan;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [3:0]  rsp_tuser;

   scan_type          scan_mode = SCAN_IDLE;
   jsvl_pkg::num_type num_phase = jsvl_pkg::NS_START;
   logic [15:0]       hex_acc = 16'h0000;
   logic [1:0]        hex_count = 2'd0;
   jsvl_pkg::lit_type lit_kind = jsvl_pkg::LIT_TRUE;
   int                lit_pos = 0;
   string             lit_spell [3] = '{"true", "false", "null"};

   lex_event    expected_events [$];
   int          mismatches = 0;
   int          items_counted = 0;
   int          burst_left = 0;
   bit          hold_off_req = 1'b0;

   beat_plan directed_rows [27] = '{
      '{8'hFF, 1'b0, 1'b1, 1'b1, jsvl_pkg::EV_ERROR, 8'hFF, jsvl_pkg::ER_START},
      '{8'h09, 1'b0, 1'b1, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE},
      '{8'h00, 1'b1, 1'b1, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE},
      '{jsvl_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE},
      '{8'h80, 1'b0, 1'b1, 1'b1, jsvl_pkg::EV_SBYTE, 8'h80, jsvl_pkg::ER_NONE},
      '{jsvl_pkg::CH_BSLASH, 1'b0, 1'b0, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE},
      '{"n",   1'b0, 1'b1, 1'b1, jsvl_pkg::EV_SBYTE, 8'h0A, jsvl_pkg::ER_NONE},
      '{jsvl_pkg::CH_BSLASH, 1'b0, 1'b0, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE},
      '{"u",   1'b0, 1'b0, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE},
      '{"F",   1'b0, 1'b0, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE},
      '{"0",   1'b0, 1'b0, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE},
      '{"a",   1'b0, 1'b0, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE},
      '{"f",   1'b0, 1'b0, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE},
      '{jsvl_pkg::CH_QUOTE, 1'b0, 1'b1, 1'b1, jsvl_pkg::EV_SEND, 8'h00, jsvl_pkg::ER_NONE},
      '{jsvl_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE},
      '{jsvl_pkg::CH_BSLASH, 1'b0, 1'b0, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE},
      '{"q",   1'b0, 1'b1, 1'b1, jsvl_pkg::EV_ERROR, "q",   jsvl_pkg::ER_ESC},
      '{"-",   1'b0, 1'b0, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE},
      '{"5",   1'b0, 1'b0, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE},
      '{"e",   1'b0, 1'b0, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE},
      '{"9",   1'b0, 1'b0, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE},
      '{"]",   1'b0, 1'b0, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE},
      '{"n",   1'b0, 1'b0, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE},
      '{"u",   1'b0, 1'b0, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE},
      '{8'hA5, 1'b1, 1'b1, 1'b1, jsvl_pkg::EV_ERROR, 8'h00, jsvl_pkg::ER_EOF},
      '{"t",   1'b0, 1'b0, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE},
      '{"x",   1'b0, 1'b1, 1'b1, jsvl_pkg::EV_ERROR, "x",   jsvl_pkg::ER_LIT}
   };

   json_scalar_value_lexer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #15_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic logic is_numeral(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h0A) || (c == 8'h0D) || (c == 8'h09);
   endfunction

   function automatic int hex_nibble(input logic [7:0] c);
      if (is_numeral(c)) return int'(c) - 48;
      if ((c >= "a") && (c <= "f")) return int'(c) - 87;
      if ((c >= "A") && (c <= "F")) return int'(c) - 55;
      return -1;
   endfunction

   function automatic logic escape_byte(input logic [7:0] c, output logic [7:0] m);
      m = c;
      case (c)
         jsvl_pkg::CH_QUOTE, jsvl_pkg::CH_BSLASH, "/": m = c;
         "b": m = 8'h08;
         "f": m = 8'h0C;
         "n": m = 8'h0A;
         "r": m = 8'h0D;
         "t": m = 8'h09;
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic jsvl_pkg::num_type number_step(input jsvl_pkg::num_type s,
                                                     input logic [7:0] c);
      jsvl_pkg::num_type nxt;
      logic              expo;
      nxt = jsvl_pkg::NS_REJECT;
      expo = (c == "e") || (c == "E");
      case (s)
         jsvl_pkg::NS_START, jsvl_pkg::NS_MINUS: begin
            if (is_numeral(c)) nxt = (c == "0") ? jsvl_pkg::NS_ZERO : jsvl_pkg::NS_INT;
            else if ((s == jsvl_pkg::NS_START) && (c == "-")) nxt = jsvl_pkg::NS_MINUS;
         end
         jsvl_pkg::NS_ZERO, jsvl_pkg::NS_INT: begin
            if (c == ".") nxt = jsvl_pkg::NS_DOT;
            else if (expo) nxt = jsvl_pkg::NS_EXP;
            else if ((s == jsvl_pkg::NS_INT) && is_numeral(c)) nxt = jsvl_pkg::NS_INT;
         end
         jsvl_pkg::NS_DOT, jsvl_pkg::NS_FRAC: begin
            if (is_numeral(c)) nxt = jsvl_pkg::NS_FRAC;
            else if ((s == jsvl_pkg::NS_FRAC) && expo) nxt = jsvl_pkg::NS_EXP;
         end
         jsvl_pkg::NS_EXP: begin
            if ((c == "+") || (c == "-")) nxt = jsvl_pkg::NS_EXP_SIGN;
            else if (is_numeral(c)) nxt = jsvl_pkg::NS_EXP_DIGIT;
         end
         jsvl_pkg::NS_EXP_SIGN, jsvl_pkg::NS_EXP_DIGIT: begin
            if (is_numeral(c)) nxt = jsvl_pkg::NS_EXP_DIGIT;
         end
         default: nxt = jsvl_pkg::NS_REJECT;
      endcase
      return nxt;
   endfunction

   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic lex_step(input logic [7:0] c, input logic eoi, output logic hit,
                           output lex_event r);
      logic [7:0]        mapped;
      int                nib;
      jsvl_pkg::num_type nxt;
      string             word;
      hit = 1'b0;
      r = '{jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE};
      if (scan_mode == SCAN_IDLE) begin
         if (eoi || is_blank(c)) begin
         end else if (c == jsvl_pkg::CH_QUOTE) begin
            scan_mode = SCAN_STRING;
         end else if ((c == "-") || is_numeral(c)) begin
            num_phase = number_step(jsvl_pkg::NS_START, c);
            scan_mode = SCAN_NUMBER;
            hit = 1'b1;
            r = '{jsvl_pkg::EV_NBYTE, c, jsvl_pkg::ER_NONE};
         end else if ((c == "t") || (c == "f") || (c == "n")) begin
            lit_kind = (c == "t") ? jsvl_pkg::LIT_TRUE :
                       ((c == "f") ? jsvl_pkg::LIT_FALSE : jsvl_pkg::LIT_NULL);
            lit_pos = 1;
            scan_mode = SCAN_LITERAL;
         end else begin
            hit = 1'b1;
            r = '{jsvl_pkg::EV_ERROR, c, jsvl_pkg::ER_START};
         end
      end else if (eoi) begin
         hit = 1'b1;
         r = '{jsvl_pkg::EV_ERROR, 8'h00, jsvl_pkg::ER_EOF};
      end else begin
         case (scan_mode)
            SCAN_STRING: begin
               if (c == jsvl_pkg::CH_QUOTE) begin
                  scan_mode = SCAN_IDLE;
                  hit = 1'b1;
                  r = '{jsvl_pkg::EV_SEND, 8'h00, jsvl_pkg::ER_NONE};
               end else if (c == jsvl_pkg::CH_BSLASH) begin
                  scan_mode = SCAN_ESCAPE;
               end else begin
                  hit = 1'b1;
                  r = '{jsvl_pkg::EV_SBYTE, c, jsvl_pkg::ER_NONE};
               end
            end
            SCAN_ESCAPE: begin
               hit = 1'b1;
               if (c == "u") begin
                  hit = 1'b0;
                  hex_acc = 16'h0000;
                  hex_count = 2'd0;
                  scan_mode = SCAN_HEX;
               end else if (escape_byte(c, mapped)) begin
                  scan_mode = SCAN_STRING;
                  r = '{jsvl_pkg::EV_SBYTE, mapped, jsvl_pkg::ER_NONE};
               end else begin
                  r = '{jsvl_pkg::EV_ERROR, c, jsvl_pkg::ER_ESC};
               end
            end
            SCAN_HEX: begin
               nib = hex_nibble(c);
               if (nib < 0) begin
                  hit = 1'b1;
                  r = '{jsvl_pkg::EV_ERROR, c, jsvl_pkg::ER_HEX};
               end else begin
                  hex_acc = {hex_acc[11:0], nib[3:0]};
                  if (hex_count == 2'd3) begin
                     hex_count = 2'd0;
                     scan_mode = SCAN_STRING;
                     hit = 1'b1;
                     r = '{jsvl_pkg::EV_SBYTE, hex_acc[7:0], jsvl_pkg::ER_NONE};
                  end else begin
                     hex_count = hex_count + 2'd1;
                  end
               end
            end
            SCAN_NUMBER: begin
               nxt = number_step(num_phase, c);
               hit = 1'b1;
               if (nxt != jsvl_pkg::NS_REJECT) begin
                  num_phase = nxt;
                  r = '{jsvl_pkg::EV_NBYTE, c, jsvl_pkg::ER_NONE};
               end else if ((num_phase == jsvl_pkg::NS_ZERO) ||
                            (num_phase == jsvl_pkg::NS_INT)) begin
                  scan_mode = SCAN_IDLE;
                  num_phase = jsvl_pkg::NS_START;
                  r = '{jsvl_pkg::EV_INT, c, jsvl_pkg::ER_NONE};
               end else if ((num_phase == jsvl_pkg::NS_FRAC) ||
                            (num_phase == jsvl_pkg::NS_EXP_DIGIT)) begin
                  scan_mode = SCAN_IDLE;
                  num_phase = jsvl_pkg::NS_START;
                  r = '{jsvl_pkg::EV_FLOAT, c, jsvl_pkg::ER_NONE};
               end else begin
                  r = '{jsvl_pkg::EV_ERROR, c, jsvl_pkg::ER_NUM};
               end
            end
            SCAN_LITERAL: begin
               word = lit_spell[int'(lit_kind)];
               if ((lit_pos >= word.len()) || (word[lit_pos] != c)) begin
                  hit = 1'b1;
                  r = '{jsvl_pkg::EV_ERROR, c, jsvl_pkg::ER_LIT};
               end else begin
                  lit_pos++;
                  if (lit_pos == word.len()) begin
                     scan_mode = SCAN_IDLE;
                     lit_pos = 0;
                     hit = 1'b1;
                     r.ev = (lit_kind == jsvl_pkg::LIT_TRUE) ? jsvl_pkg::EV_TRUE :
                            ((lit_kind == jsvl_pkg::LIT_FALSE) ? jsvl_pkg::EV_FALSE :
                             jsvl_pkg::EV_NULL);
                  end
               end
            end
            default: scan_mode = SCAN_IDLE;
         endcase
      end
      if (hit && (r.ev == jsvl_pkg::EV_ERROR)) begin
         scan_mode = SCAN_IDLE;
         num_phase = jsvl_pkg::NS_START;
      end
   endtask

   task automatic offer(input beat_plan row);
      int unsigned gap;
      logic        hit;
      lex_event    got;
      gap = 0;
      if (burst_left != 0) burst_left--;
      else gap = idle_len();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= row.ch;
      req_tlast <= row.eoi;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!((scan_mode == SCAN_IDLE) && (row.eoi || is_blank(row.ch)))) items_counted++;
      lex_step(row.ch, row.eoi, hit, got);
      if (row.typed) begin
         hit = row.has;
         got = '{row.ev, row.data, row.code};
      end
      if (hit) expected_events.push_back(got);
   endtask

   task automatic send(input logic [7:0] c, input logic eoi);
      offer('{c, eoi, 1'b0, 1'b0, jsvl_pkg::EV_SBYTE, 8'h00, jsvl_pkg::ER_NONE});
   endtask

   task automatic send_digits(input int unsigned n);
      repeat (n) send(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
   endtask

   task automatic send_hex_digit();
      string hex_set;
      hex_set = "0123456789abcdefABCDEF";
      send(hex_set[$urandom_range(0, 21)], 1'b0);
   endtask

   task automatic send_blank();
      case ($urandom_range(0, 3))
         0: send(8'h20, 1'b0);
         1: send(8'h0A, 1'b0);
         2: send(8'h0D, 1'b0);
         default: send(8'h09, 1'b0);
      endcase
   endtask

   task automatic send_string();
      logic [7:0] b;
      string      esc_set;
      esc_set = "\"\\/bfnrt";
      send(jsvl_pkg::CH_QUOTE, 1'b0);
      repeat ($urandom_range(0, 6)) begin
         case ($urandom_range(0, 5))
            0, 1, 2: begin
               do b = 8'($urandom_range(0, 255));
               while ((b == jsvl_pkg::CH_QUOTE) || (b == jsvl_pkg::CH_BSLASH));
               send(b, 1'b0);
            end
            3, 4: begin
               send(jsvl_pkg::CH_BSLASH, 1'b0);
               send(esc_set[$urandom_range(0, 7)], 1'b0);
            end
            default: begin
               send(jsvl_pkg::CH_BSLASH, 1'b0);
               send("u", 1'b0);
               repeat (4) send_hex_digit();
            end
         endcase
      end
      send(jsvl_pkg::CH_QUOTE, 1'b0);
   endtask

   task automatic send_number();
      if ($urandom_range(0, 2) == 0) send("-", 1'b0);
      if ($urandom_range(0, 3) == 0) begin
         send("0", 1'b0);
      end else begin
         send(8'h30 + 8'($urandom_range(1, 9)), 1'b0);
         send_digits($urandom_range(0, 4));
      end
      if ($urandom_range(0, 1) == 1) begin
         send(".", 1'b0);
         send_digits($urandom_range(1, 3));
      end
      if ($urandom_range(0, 2) == 0) begin
         send(($urandom_range(0, 1) == 1) ? "e" : "E", 1'b0);
         case ($urandom_range(0, 2))
            0: send("+", 1'b0);
            1: send("-", 1'b0);
            default: begin
            end
         endcase
         send_digits($urandom_range(1, 3));
      end
      case ($urandom_range(0, 5))
         0: send(",", 1'b0);
         1: send("]", 1'b0);
         2: send("}", 1'b0);
         3: send_blank();
         default: send(8'($urandom_range(0, 255)), 1'b0);
      endcase
   endtask

   task automatic send_literal();
      string word;
      word = lit_spell[$urandom_range(0, 2)];
      for (int i = 0; i < word.len(); i++) send(word[i], 1'b0);
   endtask

   task automatic send_tail();
      if ($urandom_range(0, 2) == 0) send(8'($urandom_range(0, 255)), 1'b1);
      else send(8'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic send_broken();
      string word;
      case ($urandom_range(0, 5))
         0: begin
            send(jsvl_pkg::CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 3)) send("k", 1'b0);
            send(8'($urandom_range(0, 255)), 1'b1);
         end
         1: begin
            send(jsvl_pkg::CH_QUOTE, 1'b0);
            send(jsvl_pkg::CH_BSLASH, 1'b0);
            send_tail();
         end
         2: begin
            send(jsvl_pkg::CH_QUOTE, 1'b0);
            send(jsvl_pkg::CH_BSLASH, 1'b0);
            send("u", 1'b0);
            repeat ($urandom_range(0, 3)) send_hex_digit();
            send_tail();
         end
         3: begin
            word = lit_spell[$urandom_range(0, 2)];
            for (int i = 0; i < $urandom_range(1, word.len() - 1); i++) send(word[i], 1'b0);
            send_tail();
         end
         4: begin
            case ($urandom_range(0, 3))
               0: send("-", 1'b0);
               1: begin
                  send("1", 1'b0);
                  send(".", 1'b0);
               end
               2: begin
                  send("2", 1'b0);
                  send("e", 1'b0);
               end
               default: begin
                  send("3", 1'b0);
                  send("E", 1'b0);
                  send("+", 1'b0);
               end
            endcase
            send_tail();
         end
         default: send_tail();
      endcase
   endtask

   initial begin
      int unsigned run;
      int unsigned stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            stall = idle_len();
            if (stall != 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 6);
         repeat (run) @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_rsp
      lex_event want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected beat: event %0d data %h code %0d",
                        rsp_tuser, rsp_tdata[7:0], rsp_tdata[10:8]);
         end else begin
            want = expected_events.pop_front();
            if ((rsp_tuser !== want.ev) || (rsp_tdata[7:0] !== want.data) ||
                (rsp_tdata[10:8] !== want.code)) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected event %0d data %h code %0d, got %0d %h %0d",
                           want.ev, want.data, want.code,
                           rsp_tuser, rsp_tdata[7:0], rsp_tdata[10:8]);
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned pick;
      bit          held;
      bit          drained;
      held = 1'b0;
      drained = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) offer(directed_rows[i]);
      items_counted = 0;
      while (items_counted < RANDOM_BYTES) begin
         if (!held && (items_counted >= 500)) begin
            held = 1'b1;
            hold_off_req = 1'b1;
            burst_left = 120;
         end
         if (!drained && (items_counted >= 1100)) begin
            drained = 1'b1;
            req_tvalid <= 1'b0;
            do @(posedge clock);
            while (expected_events.size() != 0);
         end
         if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(20, 80);
         pick = $urandom_range(0, 99);
         if (pick < 30) send_string();
         else if (pick < 55) send_number();
         else if (pick < 70) send_literal();
         else if (pick < 78) repeat ($urandom_range(1, 3)) send_blank();
         else if (pick < 92) send_broken();
         else send_tail();
      end
      req_tvalid <= 1'b0;
      do @(posedge clock);
      while (expected_events.size() != 0);
      repeat (10) @(posedge clock);
      mismatches += expected_events.size();
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/jsvl_pkg.sv
src/jsvl_in_reg.sv
src/jsvl_core.sv
src/jsvl_out_reg.sv
src/json_scalar_value_lexer.sv
sim/tb_json_scalar_value_lexer.sv
